>>> design/canonical_huffman_table_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the canonical Huffman table decoder
// Shared property wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef CANONICAL_HUFFMAN_TABLE_DECODER_TOP_DEFINES_SVH
`define CANONICAL_HUFFMAN_TABLE_DECODER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Check on every clock edge outside reset
`define CHTD_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Check on every clock edge, reset included
`define CHTD_ASSERT_NORST(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CHTD_ASSERT(name, prop, msg)
`define CHTD_ASSERT_NORST(name, prop, msg)
`endif
`endif

>>> design/chtd_pkg.sv
// ----------------------------------------------------------------------------
// chtd_pkg
// Types, constants and helpers of the canonical Huffman table decoder.
// ----------------------------------------------------------------------------
package chtd_pkg;

  localparam int unsigned MAX_SYMBOLS = 288;
  localparam int unsigned HEAD_BITS   = 9;
  localparam int unsigned MAX_LENGTH  = 15;
  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned HEAD_SIZE   = 1 << HEAD_BITS;
  localparam int unsigned SYM_W       = 9;
  localparam int unsigned LEN_W       = 4;
  localparam int unsigned CODE_W      = 15;
  localparam int unsigned TAB_AW      = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W       = TAB_AW + 1;
  localparam int unsigned SIZE_W      = 16;

  localparam logic [4:0]  UNUSED_LEN   = 5'd16;
  localparam logic [15:0] MARKER_VALUE = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_BUILD  = 2'd1,
    OP_DECODE = 2'd2,
    OP_NOP    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    CFG_SYMBOL_COUNT    = 1'b0,
    CFG_MAX_CODE_LENGTH = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [8:0]  symbol_index;
    logic [3:0]  code_length;
    logic [14:0] lookahead_bits;
  } item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] decoded_symbol;
    logic [3:0] bits_consumed;
    logic       symbol_invalid;
  } result_t;

  typedef struct packed {
    logic [4:0]  len;
    logic [15:0] val;
  } tab_entry_t;

  // Reverse the low len bits of a code (stream order is LSB first)
  function automatic logic [14:0] flip_code(input logic [14:0] code, input logic [3:0] len);
    logic [14:0] up;
    logic [14:0] r;
    up = code << (4'd15 - len);
    for (int i = 0; i < 15; i++) begin
      r[i] = up[14 - i];
    end
    return r;
  endfunction

endpackage

>>> design/chtd_if.sv
// ----------------------------------------------------------------------------
// chtd_in_if / chtd_out_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
interface chtd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [8:0]  symbol_index;
  logic [3:0]  code_length;
  logic [14:0] lookahead_bits;
  modport source (output valid, op, symbol_index, code_length, lookahead_bits, input ready);
  modport sink   (input valid, op, symbol_index, code_length, lookahead_bits, output ready);
endinterface

interface chtd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [8:0] decoded_symbol;
  logic [3:0] bits_consumed;
  logic       symbol_invalid;
  modport source (output valid, status, decoded_symbol, bits_consumed, symbol_invalid,
                  input ready);
  modport sink   (input valid, status, decoded_symbol, bits_consumed, symbol_invalid,
                  output ready);
endinterface

>>> design/chtd_ram.sv
// ----------------------------------------------------------------------------
// chtd_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module chtd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and read the array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/chtd_ctrl.sv
// ----------------------------------------------------------------------------
// chtd_ctrl
// Sequencer and shared datapath: loads lengths, builds the two-level table
// one entry per step, and walks it for decode.
// ----------------------------------------------------------------------------
`include "canonical_huffman_table_decoder_top_defines.svh"

module chtd_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  chtd_pkg::item_t   item_i,
  input  logic [8:0]        sym_count_i,
  input  logic [3:0]        max_len_i,
  output logic              idle_o,
  output logic              res_valid_o,
  input  logic              res_take_i,
  output chtd_pkg::result_t res_o
);
  import chtd_pkg::*;

  typedef enum logic [24:0] {
    S_IDLE   = 25'd1 << 0,
    S_DEC1   = 25'd1 << 1,
    S_DEC2   = 25'd1 << 2,
    S_DEC3   = 25'd1 << 3,
    S_PCLR   = 25'd1 << 4,
    S_CNT_RD = 25'd1 << 5,
    S_CNT_EX = 25'd1 << 6,
    S_NXT    = 25'd1 << 7,
    S_ASG_RD = 25'd1 << 8,
    S_ASG_EX = 25'd1 << 9,
    S_ASG_PM = 25'd1 << 10,
    S_SIZ_RD = 25'd1 << 11,
    S_SIZ_EX = 25'd1 << 12,
    S_TCLR   = 25'd1 << 13,
    S_PTR_RD = 25'd1 << 14,
    S_PTR_EX = 25'd1 << 15,
    S_FIL_RD = 25'd1 << 16,
    S_FIL_EX = 25'd1 << 17,
    S_FIL_TP = 25'd1 << 18,
    S_ENT_RD = 25'd1 << 19,
    S_ENT_WR = 25'd1 << 20,
    S_FIN_RD = 25'd1 << 21,
    S_FIN_EX = 25'd1 << 22,
    S_DONE   = 25'd1 << 23,
    S_SPARE  = 25'd1 << 24
  } state_e;

  state_e            state_q, state_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [3:0]        b_q, b_d;
  logic [8:0]        j_q, j_d;
  logic [8:0]        last_q, last_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [IDX_W-1:0]  ptr_q, ptr_d;
  logic [1:0]        present_q, present_d;
  logic [3:0]        cur_len_q, cur_len_d;
  logic [14:0]       cur_rev_q, cur_rev_d;
  logic [IDX_W-1:0]  base_q, base_d;
  logic [14:0]       look_q, look_d;
  logic              ready_q, ready_d;
  result_t           res_q, res_d;
  logic [8:0]        cnt_q [16];
  logic [8:0]        cnt_d [16];
  logic [15:0]       nxt_q [16];
  logic [15:0]       nxt_d [16];

  // RAM ports
  logic              len_we;
  logic [8:0]        len_waddr;
  logic [3:0]        len_rdata;
  logic              code_we;
  logic [14:0]       code_wdata, code_rdata;
  logic              pm_we;
  logic [8:0]        pm_waddr, pm_raddr;
  logic [3:0]        pm_wdata, pm_rdata;
  logic              tab_we;
  logic [TAB_AW-1:0] tab_waddr, tab_raddr;
  tab_entry_t        tab_wdata, tab_rdata;

  logic [8:0]        n_sym;
  logic [3:0]        l_rd;
  logic [14:0]       code_new, rev_new;
  logic [8:0]        ent_head;
  logic [6:0]        ent_off;
  logic [IDX_W:0]    ent_idx;
  logic              ent_in_size;
  logic [5:0]        sec_extra;
  logic [16:0]       sec_sum;
  logic [3:0]        b_prev;
  logic [8:0]        cnt_prev;

  chtd_ram #(.WIDTH(4), .DEPTH(MAX_SYMBOLS)) u_len_ram (
    .clk_i, .we_i(len_we), .waddr_i(len_waddr), .wdata_i(item_i.code_length),
    .raddr_i(idx_q[8:0]), .rdata_o(len_rdata)
  );

  chtd_ram #(.WIDTH(15), .DEPTH(MAX_SYMBOLS)) u_code_ram (
    .clk_i, .we_i(code_we), .waddr_i(idx_q[8:0]), .wdata_i(code_wdata),
    .raddr_i(idx_q[8:0]), .rdata_o(code_rdata)
  );

  chtd_ram #(.WIDTH(4), .DEPTH(HEAD_SIZE)) u_pm_ram (
    .clk_i, .we_i(pm_we), .waddr_i(pm_waddr), .wdata_i(pm_wdata),
    .raddr_i(pm_raddr), .rdata_o(pm_rdata)
  );

  chtd_ram #(.WIDTH(21), .DEPTH(TABLE_DEPTH)) u_tab_ram (
    .clk_i, .we_i(tab_we), .waddr_i(tab_waddr), .wdata_i(tab_wdata),
    .raddr_i(tab_raddr), .rdata_o(tab_rdata)
  );

  // Pack a decode answer from a table entry
  function automatic result_t dec_res(input logic [4:0] l, input logic [15:0] v,
                                      input logic [3:0] used);
    result_t r;
    logic    bad;
    bad = (l > 5'(MAX_LENGTH)) || (v == MARKER_VALUE) || (v >= 16'(MAX_SYMBOLS));
    r.status         = ST_OK;
    r.decoded_symbol = bad ? 9'd0 : v[8:0];
    r.bits_consumed  = used;
    r.symbol_invalid = bad;
    return r;
  endfunction

  // Shared address and index arithmetic
  always_comb begin
    n_sym     = (sym_count_i > 9'(MAX_SYMBOLS)) ? 9'(MAX_SYMBOLS) : sym_count_i;
    l_rd      = len_rdata;
    code_new  = nxt_q[l_rd][14:0] & 15'((16'd1 << l_rd) - 16'd1);
    rev_new   = flip_code(code_new, l_rd);
    ent_head  = cur_rev_q[8:0] | 9'(18'(j_q) << cur_len_q);
    ent_off   = 7'(cur_rev_q[14:9]) | 7'(16'(j_q) << (cur_len_q - 4'd9));
    ent_idx   = (cur_len_q <= 4'(HEAD_BITS)) ? (IDX_W+1)'(ent_head)
                                             : (IDX_W+1)'(base_q) + (IDX_W+1)'(ent_off);
    ent_in_size = 17'(ent_idx) < 17'(size_q);
    sec_extra = look_q[14:9] & 6'((7'd1 << (tab_rdata.len[3:0] - 4'd9)) - 7'd1);
    sec_sum   = 17'(tab_rdata.val) + 17'(sec_extra);
    b_prev    = b_q - 4'd1;
    cnt_prev  = (b_q == 4'd1) ? 9'd0 : cnt_q[b_prev];
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    b_d       = b_q;
    j_d       = j_q;
    last_d    = last_q;
    size_d    = size_q;
    ptr_d     = ptr_q;
    present_d = present_q;
    cur_len_d = cur_len_q;
    cur_rev_d = cur_rev_q;
    base_d    = base_q;
    look_d    = look_q;
    ready_d   = ready_q;
    res_d     = res_q;
    cnt_d     = cnt_q;
    nxt_d     = nxt_q;
    len_we    = 1'b0;
    len_waddr = item_i.symbol_index;
    code_we   = 1'b0;
    code_wdata = rev_new;
    pm_we     = 1'b0;
    pm_waddr  = idx_q[8:0];
    pm_wdata  = 4'd0;
    pm_raddr  = idx_q[8:0];
    tab_we    = 1'b0;
    tab_waddr = idx_q[TAB_AW-1:0];
    tab_wdata = '{len: UNUSED_LEN, val: 16'd0};
    tab_raddr = idx_q[TAB_AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d  = '0;
          look_d = item_i.lookahead_bits;
          unique case (op_e'(item_i.op))
            OP_LOAD: begin
              len_we  = item_i.symbol_index < 9'(MAX_SYMBOLS);
              ready_d = 1'b0;
              state_d = S_DONE;
            end
            OP_BUILD: begin
              ready_d = 1'b0;
              idx_d   = '0;
              state_d = S_PCLR;
            end
            OP_DECODE: begin
              if (ready_q) begin
                state_d = S_DEC1;
              end else begin
                res_d.symbol_invalid = 1'b1;
                state_d = S_DONE;
              end
            end
            OP_NOP: state_d = S_DONE;
            default: state_d = S_DONE;
          endcase
        end
      end
      // Decode: head read, then optional secondary read
      S_DEC1: begin
        tab_raddr = TAB_AW'(look_q[HEAD_BITS-1:0]);
        state_d   = S_DEC2;
      end
      S_DEC2: begin
        state_d = S_DONE;
        if (tab_rdata.len <= 5'(HEAD_BITS)) begin
          res_d = dec_res(tab_rdata.len, tab_rdata.val, tab_rdata.len[3:0]);
        end else if (tab_rdata.len <= 5'(MAX_LENGTH)) begin
          if (sec_sum < 17'(TABLE_DEPTH)) begin
            tab_raddr = sec_sum[TAB_AW-1:0];
            state_d   = S_DEC3;
          end else begin
            res_d = dec_res(UNUSED_LEN, tab_rdata.val, 4'd0);
          end
        end else begin
          res_d = dec_res(tab_rdata.len, tab_rdata.val, 4'd0);
        end
      end
      S_DEC3: begin
        res_d = dec_res(tab_rdata.len, tab_rdata.val,
                        (tab_rdata.len <= 5'(MAX_LENGTH)) ? tab_rdata.len[3:0] : 4'd0);
        state_d = S_DONE;
      end
      // Clear the prefix-length memory and the counters
      S_PCLR: begin
        pm_we = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q == IDX_W'(HEAD_SIZE - 1)) begin
          idx_d   = '0;
          for (int k = 0; k < 16; k++) begin
            cnt_d[k] = '0;
            nxt_d[k] = '0;
          end
          state_d = S_CNT_RD;
        end
      end
      // Count lengths
      S_CNT_RD: begin
        if (idx_q >= IDX_W'(n_sym)) begin
          b_d     = 4'd1;
          state_d = S_NXT;
        end else begin
          state_d = S_CNT_EX;
        end
      end
      S_CNT_EX: begin
        if (l_rd > max_len_i) begin
          res_d.status = ST_INVALID;
          state_d      = S_DONE;
        end else begin
          cnt_d[l_rd] = cnt_q[l_rd] + 9'd1;
          idx_d       = idx_q + 1'b1;
          state_d     = S_CNT_RD;
        end
      end
      // First code of each length
      S_NXT: begin
        nxt_d[b_q] = 16'((17'(nxt_q[b_prev]) + 17'(cnt_prev)) << 1);
        b_d        = b_q + 4'd1;
        if (b_q == 4'(MAX_LENGTH)) begin
          idx_d   = '0;
          state_d = S_ASG_RD;
        end
      end
      // Assign codes and track the longest code under each head prefix
      S_ASG_RD: begin
        if (idx_q >= IDX_W'(n_sym)) begin
          idx_d   = '0;
          size_d  = SIZE_W'(HEAD_SIZE);
          state_d = S_SIZ_RD;
        end else begin
          state_d = S_ASG_EX;
        end
      end
      S_ASG_EX: begin
        idx_d   = idx_q + 1'b1;
        state_d = S_ASG_RD;
        if (l_rd != 4'd0) begin
          code_we     = 1'b1;
          nxt_d[l_rd] = nxt_q[l_rd] + 16'd1;
          if (l_rd > 4'(HEAD_BITS)) begin
            pm_raddr  = rev_new[8:0];
            cur_len_d = l_rd;
            cur_rev_d = rev_new;
            idx_d     = idx_q;
            state_d   = S_ASG_PM;
          end
        end
      end
      S_ASG_PM: begin
        pm_waddr = cur_rev_q[8:0];
        pm_wdata = cur_len_q;
        pm_we    = pm_rdata < cur_len_q;
        idx_d    = idx_q + 1'b1;
        state_d  = S_ASG_RD;
      end
      // Sum the secondary table sizes
      S_SIZ_RD: begin
        if (idx_q == IDX_W'(HEAD_SIZE)) begin
          if (size_q > SIZE_W'(TABLE_DEPTH)) begin
            res_d.status = ST_OVERFLOW;
            state_d      = S_DONE;
          end else begin
            idx_d   = '0;
            state_d = S_TCLR;
          end
        end else begin
          state_d = S_SIZ_EX;
        end
      end
      S_SIZ_EX: begin
        if (pm_rdata > 4'(HEAD_BITS)) begin
          size_d = size_q + (SIZE_W'(1) << (pm_rdata - 4'd9));
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_SIZ_RD;
      end
      // Mark the used part of the table empty
      S_TCLR: begin
        tab_we = 1'b1;
        idx_d  = idx_q + 1'b1;
        if (SIZE_W'(idx_q) == size_q - 16'd1) begin
          idx_d   = '0;
          ptr_d   = IDX_W'(HEAD_SIZE);
          state_d = S_PTR_RD;
        end
      end
      // Link head entries to their secondary tables
      S_PTR_RD: begin
        if (idx_q == IDX_W'(HEAD_SIZE)) begin
          idx_d     = '0;
          present_d = 2'd0;
          state_d   = S_FIL_RD;
        end else begin
          state_d = S_PTR_EX;
        end
      end
      S_PTR_EX: begin
        if (pm_rdata > 4'(HEAD_BITS)) begin
          tab_we    = 1'b1;
          tab_wdata = '{len: 5'(pm_rdata), val: 16'(ptr_q)};
          ptr_d     = ptr_q + (IDX_W'(1) << (pm_rdata - 4'd9));
        end
        idx_d   = idx_q + 1'b1;
        state_d = S_PTR_RD;
      end
      // Fill the entries of each symbol
      S_FIL_RD: begin
        if (idx_q >= IDX_W'(n_sym)) begin
          idx_d   = '0;
          state_d = S_FIN_RD;
        end else begin
          state_d = S_FIL_EX;
        end
      end
      S_FIL_EX: begin
        cur_len_d = l_rd;
        cur_rev_d = code_rdata;
        j_d       = '0;
        if (l_rd == 4'd0) begin
          idx_d   = idx_q + 1'b1;
          state_d = S_FIL_RD;
        end else begin
          present_d = (present_q == 2'd2) ? 2'd2 : present_q + 2'd1;
          if (l_rd <= 4'(HEAD_BITS)) begin
            last_d  = 9'((10'd1 << (4'd9 - l_rd)) - 10'd1);
            state_d = S_ENT_RD;
          end else begin
            tab_raddr = TAB_AW'(code_rdata[8:0]);
            state_d   = S_FIL_TP;
          end
        end
      end
      S_FIL_TP: begin
        if ((tab_rdata.len < 5'(cur_len_q)) || (tab_rdata.len > 5'(MAX_LENGTH))) begin
          res_d.status = ST_INVALID;
          state_d      = S_DONE;
        end else begin
          base_d  = IDX_W'(tab_rdata.val);
          last_d  = 9'((10'd1 << (tab_rdata.len[3:0] - cur_len_q)) - 10'd1);
          state_d = S_ENT_RD;
        end
      end
      S_ENT_RD: begin
        if (!ent_in_size) begin
          res_d.status = ST_INVALID;
          state_d      = S_DONE;
        end else begin
          tab_raddr = ent_idx[TAB_AW-1:0];
          state_d   = S_ENT_WR;
        end
      end
      S_ENT_WR: begin
        if (tab_rdata.len != UNUSED_LEN) begin
          res_d.status = ST_INVALID;
          state_d      = S_DONE;
        end else begin
          tab_we    = 1'b1;
          tab_waddr = ent_idx[TAB_AW-1:0];
          tab_wdata = '{len: 5'(cur_len_q), val: 16'(idx_q)};
          if (j_q == last_q) begin
            idx_d   = idx_q + 1'b1;
            state_d = S_FIL_RD;
          end else begin
            j_d     = j_q + 9'd1;
            state_d = S_ENT_RD;
          end
        end
      end
      // Check for holes; mark them when the alphabet is degenerate
      S_FIN_RD: begin
        if (SIZE_W'(idx_q) == size_q) begin
          ready_d = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_FIN_EX;
        end
      end
      S_FIN_EX: begin
        state_d = S_FIN_RD;
        idx_d   = idx_q + 1'b1;
        if (tab_rdata.len == UNUSED_LEN) begin
          if (present_q == 2'd2) begin
            res_d.status = ST_INVALID;
            state_d      = S_DONE;
          end else begin
            tab_we    = 1'b1;
            tab_wdata = '{len: (idx_q < IDX_W'(HEAD_SIZE)) ? 5'd1 : 5'(HEAD_BITS + 1),
                          val: MARKER_VALUE};
          end
        end
      end
      // Hold the result until the output stage takes it
      S_DONE: begin
        if (res_take_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ready_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    b_q       <= b_d;
    j_q       <= j_d;
    last_q    <= last_d;
    size_q    <= size_d;
    ptr_q     <= ptr_d;
    present_q <= present_d;
    cur_len_q <= cur_len_d;
    cur_rev_q <= cur_rev_d;
    base_q    <= base_d;
    look_q    <= look_d;
    res_q     <= res_d;
    cnt_q     <= cnt_d;
    nxt_q     <= nxt_d;
  end

  assign idle_o      = (state_q == S_IDLE);
  assign res_valid_o = (state_q == S_DONE);
  assign res_o       = res_q;

  `CHTD_ASSERT(a_start_leaves_idle, start_i |=> (state_q != S_IDLE), "start did not leave idle")
  `CHTD_ASSERT_NORST(a_load_drops_table, (start_i && idle_o && (item_i.op == OP_LOAD)) |=> !ready_q, "load kept table ready")
  `CHTD_ASSERT(a_fill_in_bounds, (state_q == S_ENT_WR) |-> ent_in_size, "fill outside table")
  `CHTD_ASSERT(a_result_held, (res_valid_o && !res_take_i) |=> (res_valid_o && $stable(res_q)), "result dropped")

endmodule

>>> design/canonical_huffman_table_decoder_top.sv
// A load, no-op or decode without a table goes from IDLE straight to DONE; a decode first
// reads the head entry (DEC1, DEC2) and, for a long code, a secondary entry (DEC3).
// One request at a time; the
// next request is taken while the result waits at the output.
// Build: clear, count, first codes, assign, sizes, table clear, links, fill, hole check; one RAM access
// per step; an invalid tree or overflow ends it early. Reset (async, active low) clears
// control state and table ready, and sets the config registers to 288 symbols and 15.
// ----------------------------------------------------------------------------
// canonical_huffman_table_decoder_top
// Config registers, request hand-off and output stage of the table decoder.
// ----------------------------------------------------------------------------
module canonical_huffman_table_decoder_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_index_i,
  input  logic [8:0] cfg_data_i,
  chtd_in_if.sink    in_ch,
  chtd_out_if.source out_ch
);
  import chtd_pkg::*;

  logic [8:0] sym_count_q;
  logic [3:0] max_len_q;
  item_t      item;
  result_t    res, out_q;
  logic       idle, res_valid, res_take, out_valid_q, start;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_count_q <= 9'd288;
      max_len_q   <= 4'd15;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_SYMBOL_COUNT:    sym_count_q <= cfg_data_i;
        CFG_MAX_CODE_LENGTH: max_len_q   <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  assign item = '{op: in_ch.op, symbol_index: in_ch.symbol_index,
                  code_length: in_ch.code_length, lookahead_bits: in_ch.lookahead_bits};
  assign in_ch.ready = idle;
  assign start       = in_ch.valid & idle;
  assign res_take    = !out_valid_q || out_ch.ready;

  chtd_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .start_i(start), .item_i(item),
    .sym_count_i(sym_count_q), .max_len_i(max_len_q),
    .idle_o(idle), .res_valid_o(res_valid), .res_take_i(res_take), .res_o(res)
  );

  // Output stage: load a finished result, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_take) begin
      out_q <= res;
    end
  end

  assign out_ch.valid          = out_valid_q;
  assign out_ch.status         = out_q.status;
  assign out_ch.decoded_symbol = out_q.decoded_symbol;
  assign out_ch.bits_consumed  = out_q.bits_consumed;
  assign out_ch.symbol_invalid = out_q.symbol_invalid;

endmodule
